### src/psd_pkg.sv
// ============================================================================
// psd_pkg: shared types and constants for the parity steered deque
// Transfer payload structs, status and command codes, and cell control.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // Default number of storage cells in the chain.
    localparam int MAX_DEPTH_DEF = 128;

    // Widths fixed by the transfer fields.
    localparam int DATA_W = 32;
    localparam int FILL_W = 8;
    localparam int CAP_W  = 8;

    // Operation codes carried in the input transfer.
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNINIT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // One input item.
    typedef struct packed {
        t_cmd                      command;
        logic signed [DATA_W-1:0]  value;
    } t_in;

    // One result item.
    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic        [FILL_W-1:0]  fill_level;
    } t_out;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic              shift_fwd;   // push at front: take left neighbor
        logic              shift_back;  // pop: take right neighbor
        logic              push_back;   // push at back: cell at count loads value
        logic [FILL_W-1:0] count;       // current number of stored values
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/psd_cell.sv
// ============================================================================
// psd_cell: one storage cell of the deque chain
// Holds one value and moves it toward the front or back with its neighbors.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psd_cell #(
    parameter int MAX_DEPTH = psd_pkg::MAX_DEPTH_DEF,
    parameter int CELL_IDX  = 0
) (
    input  wire                                   i_clk,
    input  wire psd_pkg::t_cell_ctl               i_ctl,
    input  wire logic signed [psd_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [psd_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [psd_pkg::DATA_W-1:0] i_right,
    output logic signed      [psd_pkg::DATA_W-1:0] o_data
);
    import psd_pkg::*;

    // Compare width wide enough for both the count and this cell's index.
    localparam int IDX_W = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMP_W = (FILL_W > IDX_W) ? FILL_W : IDX_W;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_is_tail;

    // This cell is the first free slot behind the stored values.
    assign w_is_tail = (CMP_W'(i_ctl.count) == CMP_W'(CELL_IDX));

    // Next value: shift with a neighbor or load the pushed value.
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_fwd) begin
            n_data = i_left;
        end else if (i_ctl.shift_back) begin
            n_data = i_right;
        end else if (i_ctl.push_back && w_is_tail) begin
            n_data = i_value;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### src/psd_ctrl.sv
// ============================================================================
// psd_ctrl: deque controller
// Capacity register, fill count, status decision, cell control and the
// output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psd_ctrl #(
    parameter int MAX_DEPTH = psd_pkg::MAX_DEPTH_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // Input channel
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire psd_pkg::t_in                      i_in_data,
    // Output channel
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output psd_pkg::t_out                          o_out_data,
    // Configuration channel
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [psd_pkg::CAP_W-1:0]         i_cfg_data,
    // Cell chain
    input  wire logic signed [psd_pkg::DATA_W-1:0] i_front_data,
    output psd_pkg::t_cell_ctl                     o_cell_ctl
);
    import psd_pkg::*;

    logic [CAP_W-1:0]  r_capacity;
    logic [FILL_W-1:0] r_count;
    logic [FILL_W-1:0] n_count;
    logic              r_out_valid;
    t_out              r_out_data;
    t_out              n_out_data;

    logic w_accept;
    logic w_cfg_wr;
    logic w_init_ok;
    logic w_full;
    logic w_empty;
    logic w_push_front;
    logic w_push_back;
    logic w_pop;

    // Handshakes: the output register frees up when its transfer completes.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // A capacity of zero or above the cell count means not initialized.
    assign w_init_ok = (r_capacity != '0) && !(32'(r_capacity) > 32'(MAX_DEPTH));
    assign w_full    = (r_count >= r_capacity);
    assign w_empty   = (r_count == '0);

    // Decide the operation and its status.
    always_comb begin
        w_push_front          = 1'b0;
        w_push_back           = 1'b0;
        w_pop                 = 1'b0;
        n_count               = r_count;
        n_out_data.status     = ST_OK;
        n_out_data.read_value = '0;
        if (!w_init_ok) begin
            n_out_data.status = ST_UNINIT;
        end else if (i_in_data.command == CMD_PUSH) begin
            if (w_full) begin
                n_out_data.status = ST_FULL;
            end else begin
                // Odd values enter at the front, even values at the back.
                w_push_front = i_in_data.value[0];
                w_push_back  = !i_in_data.value[0];
                n_count      = r_count + FILL_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_data.status = ST_EMPTY;
            end else begin
                w_pop                 = 1'b1;
                n_out_data.read_value = i_front_data;
                n_count               = r_count - FILL_W'(1);
            end
        end
        n_out_data.fill_level = n_count;
    end

    // Cell control is only active on an accepted transfer.
    always_comb begin
        o_cell_ctl.shift_fwd  = w_accept && w_push_front;
        o_cell_ctl.shift_back = w_accept && w_pop;
        o_cell_ctl.push_back  = w_accept && w_push_back;
        o_cell_ctl.count      = r_count;
    end

    // Capacity and fill count; a capacity write empties the deque.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_count    <= '0;
        end else if (w_cfg_wr) begin
            r_capacity <= i_cfg_data;
            r_count    <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload holds while stalled.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_capacity)
        else $error("fill count above capacity");

    // A successful push raises the count by one.
    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_push_front || w_push_back) && !w_cfg_wr)
        |=> (r_count == $past(r_count) + FILL_W'(1)))
        else $error("push did not raise fill count");

    // A successful pop lowers the count by one.
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_pop && !w_cfg_wr)
        |=> (r_count == $past(r_count) - FILL_W'(1)))
        else $error("pop did not lower fill count");

    // A not-initialized result always reports an empty deque.
    a_uninit_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status == ST_UNINIT))
        |-> (r_out_data.fill_level == '0))
        else $error("not-initialized result with nonzero fill level");

endmodule

`default_nettype wire

### src/parity_steered_deque.sv
// ============================================================================
// parity_steered_deque: bounded deque of signed values steered by parity
// A chain of storage cells with the front at cell zero, plus a controller.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries a command and
//   a value. A push places an odd value at the front and an even value at the
//   back; a pop removes the front value. Each transfer gives exactly one
//   result on the output channel (o_out_valid / i_out_stall / o_out_data)
//   with a status, the popped value (zero unless a pop succeeds) and the
//   fill level after the operation.
//   The result is registered at the edge that takes the input transfer.
//   Throughput is one item per cycle while the output is not stalled;
//   every cell shifts or loads in the same cycle.
//   When the receiver stalls, the result register holds and o_in_stall is
//   raised until the result transfer completes.
//   The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   the capacity and empties the deque; it is always ready.
//   After reset the capacity is zero, so every operation reports not
//   initialized until a capacity from 1 to MAX_DEPTH is written. There is no
//   clearing pass; cells are only read after a push has filled them.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module parity_steered_deque #(
    parameter int MAX_DEPTH = psd_pkg::MAX_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire psd_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output psd_pkg::t_out                  o_out_data,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [psd_pkg::CAP_W-1:0] i_cfg_data
);
    import psd_pkg::*;

    t_cell_ctl                w_cell_ctl;
    logic signed [DATA_W-1:0] w_cell_data [MAX_DEPTH];

    // Controller: capacity, count, status and output register.
    psd_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_front_data (w_cell_data[0]),
        .o_cell_ctl   (w_cell_ctl)
    );

    // Cell chain: cell zero is the front; the pushed value enters at either end.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_in_data.value;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end

        if (g == MAX_DEPTH - 1) begin : g_tail
            assign w_right = w_cell_data[g];
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end

        psd_cell #(
            .MAX_DEPTH (MAX_DEPTH),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_cell_ctl),
            .i_value (i_in_data.value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g])
        );
    end

endmodule

`default_nettype wire
